// File: sv/log_record_crc32_checker_defines.svh
// Assertion helpers shared by the checker RTL.
`ifndef LOG_RECORD_CRC32_CHECKER_DEFINES_SVH
`define LOG_RECORD_CRC32_CHECKER_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define LRCC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrcc assertion failed");

// Next-cycle implication, held off while reset is high.
`define LRCC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrcc assertion failed");

`endif

// File: sv/lrcc_pkg.sv
package lrcc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Verdict codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISMATCH  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } log_in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        record_done;
    logic [7:0]  record_type;
    logic [31:0] payload_length;
    logic [31:0] record_index;
    logic [1:0]  status;
  } result_t;

  // Reflected CRC-32, one byte per call.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/lrcc_parser.sv
`include "log_record_crc32_checker_defines.svh"

module lrcc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  lrcc_pkg::log_in_t item,
  output logic              has_result,
  output lrcc_pkg::result_t result
);
  import lrcc_pkg::*;

  // Phase: next header byte, or payload
  localparam logic [3:0] PH_TYPE    = 4'd0;
  localparam logic [3:0] PH_LEN0    = 4'd1;
  localparam logic [3:0] PH_LEN3    = 4'd4;
  localparam logic [3:0] PH_CRC0    = 4'd5;
  localparam logic [3:0] PH_CRC3    = 4'd8;
  localparam logic [3:0] PH_PAYLOAD = 4'd9;

  logic [3:0]  phase, phase_next;
  logic [31:0] remaining, remaining_next;
  logic [7:0]  held_type, held_type_next;
  logic [31:0] held_length, held_length_next;
  logic [31:0] held_crc, held_crc_next;
  logic [31:0] running_crc, running_crc_next;
  logic        halted, halted_next;
  logic [31:0] good_records, good_records_next;

  logic [31:0] crc_upd;
  logic        finished;
  logic        crc_ok;

  assign crc_upd = crc32_byte(running_crc, item.in_byte);

  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    held_type_next    = held_type;
    held_length_next  = held_length;
    held_crc_next     = held_crc;
    running_crc_next  = running_crc;
    halted_next       = halted;
    good_records_next = good_records;
    finished          = 1'b0;
    crc_ok            = 1'b0;
    result            = '0;

    if (halted) begin
      // dropping bytes until end of stream, then a fresh log
      if (item.end_of_stream) begin
        phase_next        = PH_TYPE;
        remaining_next    = '0;
        held_type_next    = '0;
        held_length_next  = '0;
        held_crc_next     = '0;
        running_crc_next  = CRC_ONES;
        halted_next       = 1'b0;
        good_records_next = '0;
      end
    end else begin
      unique case (phase) inside
        [PH_LEN0:PH_LEN3]: begin
          held_length_next = {held_length[23:0], item.in_byte};
          running_crc_next = crc_upd;
          phase_next       = phase + 4'd1;
        end
        [PH_CRC0:PH_CRC3]: begin
          held_crc_next = {held_crc[23:0], item.in_byte};
          if (phase == PH_CRC3) begin
            if (held_length == '0) begin
              finished = 1'b1;
            end else begin
              remaining_next = held_length;
              phase_next     = PH_PAYLOAD;
            end
          end else begin
            phase_next = phase + 4'd1;
          end
        end
        PH_PAYLOAD: begin
          result.payload_valid = 1'b1;
          result.payload_byte  = item.in_byte;
          running_crc_next     = crc_upd;
          remaining_next       = remaining - 32'd1;
          finished             = (remaining_next == '0);
        end
        default: begin
          // type byte; out-of-range phase codes land here as well
          held_type_next   = item.in_byte;
          held_length_next = '0;
          running_crc_next = crc_upd;
          phase_next       = PH_LEN0;
        end
      endcase

      if (finished || item.end_of_stream) begin
        result.record_done    = 1'b1;
        result.record_type    = held_type_next;
        result.payload_length = held_length_next;
        result.record_index   = good_records;
      end

      if (finished) begin
        crc_ok        = ((running_crc_next ^ CRC_ONES) == held_crc_next);
        result.status = crc_ok ? ST_OK : ST_MISMATCH;
      end else if (item.end_of_stream) begin
        result.status = ST_TRUNCATED;
      end

      if (finished || item.end_of_stream) begin
        phase_next       = PH_TYPE;
        remaining_next   = '0;
        held_type_next   = '0;
        held_length_next = '0;
        held_crc_next    = '0;
        running_crc_next = CRC_ONES;
        if (item.end_of_stream) begin
          good_records_next = '0;
        end else if (crc_ok) begin
          good_records_next = good_records + 32'd1;
        end else begin
          halted_next = 1'b1;
        end
      end
    end

    has_result = result.payload_valid | result.record_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      remaining    <= '0;
      held_type    <= '0;
      held_length  <= '0;
      held_crc     <= '0;
      running_crc  <= CRC_ONES;
      halted       <= 1'b0;
      good_records <= '0;
    end else if (step) begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      held_type    <= held_type_next;
      held_length  <= held_length_next;
      held_crc     <= held_crc_next;
      running_crc  <= running_crc_next;
      halted       <= halted_next;
      good_records <= good_records_next;
    end
  end

  `LRCC_ASSERT_IMP(a_halted_silent, clk, rst, halted, !has_result)
  `LRCC_ASSERT_IMP(a_payload_in_phase, clk, rst, result.payload_valid, phase == PH_PAYLOAD)
  `LRCC_ASSERT_NXT(a_good_count, clk, rst,
    step && result.record_done && result.status == ST_OK && !item.end_of_stream,
    good_records == $past(good_records) + 32'd1)

endmodule

// File: sv/log_record_crc32_checker.sv
// Log record CRC-32 checker.
// Input channel (log_valid / log_ready / log_item): one raw log byte per
// transaction, with end_of_stream marking the last byte of a log.
// Output channel (result_valid / result_ready / result_item): one transaction
// per payload byte passed through and per record verdict; the last payload
// byte of a record carries its verdict in the same transaction. Header bytes
// that close no record give no transaction.
// Records: type byte, big-endian length, big-endian stored CRC, payload.
// Verdicts: ok, CRC mismatch (then bytes are dropped up to end of stream),
// or truncated when end_of_stream lands inside a record.
// Path: an accepted byte waits in the input register; when it advances, its
// result is loaded into the output register and result_valid goes high.
// Throughput: one byte per cycle while the output is not stalled; the byte-wide
// CRC update and header parsing sit between the input and output registers.
// Stall: while result_ready is low and a result waits, the input register
// still takes one more byte; further bytes wait until the output drains.
// Bytes that give no result keep flowing even while the output is stalled.
// Reset (rst, synchronous): both registers empty, parser at a new log.
`include "log_record_crc32_checker_defines.svh"

module log_record_crc32_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              log_valid,
  output logic              log_ready,
  input  lrcc_pkg::log_in_t log_item,
  output logic              result_valid,
  input  logic              result_ready,
  output lrcc_pkg::result_t result_item
);
  import lrcc_pkg::*;

  // input register
  logic    s1_valid;
  log_in_t s1_item;

  // parser output for the byte held in s1
  logic    has_result;
  result_t parsed;
  logic    advance;

  // s1 moves on when its byte yields nothing or the output slot is free or being read
  assign advance   = s1_valid && (!has_result || !result_valid || result_ready);
  assign log_ready = !s1_valid || advance;

  lrcc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (s1_item),
    .has_result (has_result),
    .result     (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (log_ready) begin
      s1_valid <= log_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (log_ready && log_valid) begin
      s1_item <= log_item;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && has_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      result_item <= parsed;
    end
  end

  `LRCC_ASSERT_NXT(a_result_loaded, clk, rst, advance && has_result, result_valid)
  `LRCC_ASSERT_NXT(a_s1_held, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_item))
  `LRCC_ASSERT_IMP(a_no_overwrite, clk, rst, advance && has_result && result_valid, result_ready)

endmodule
